[rtl/jsb_pkg.sv]
// Shared constants and types for the joystick to SBUS bridge.
`default_nettype none

package jsb_pkg;

  localparam int CHANNEL_COUNT   = 16;
  localparam int CH_W            = 11;
  localparam int PAYLOAD_LEN     = 8;
  localparam int SLOT_W          = 3;
  localparam int POS_W           = 4;
  localparam int CH_BYTES        = (CHANNEL_COUNT * CH_W + 7) / 8;
  localparam int FRAME_LEN       = CH_BYTES + 3;
  localparam int FRAME_IDX_W     = $clog2(FRAME_LEN);
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int FLAGS_W         = 4;
  localparam int SCALED_W        = 19;   // b * 1640 fits in 19 bits

  localparam logic [7:0]      SYNC_BYTE  = 8'hFF;
  localparam logic [7:0]      HDR_BYTE   = 8'h0F;
  localparam logic [7:0]      FTR_BYTE   = 8'h00;
  localparam logic [CH_W-1:0] CH_NEUTRAL = 11'd992;
  localparam logic [CH_W-1:0] CH_OFFSET  = 11'd172;
  localparam logic [10:0]     AXIS_GAIN  = 11'd1640;

  // reciprocal constants: floor(x/121) and floor(x/255) over the operand range
  localparam logic [19:0] RECIP_121   = 20'd554619;
  localparam int          RECIP_121_SH = 26;
  localparam logic [19:0] RECIP_255   = 20'd526345;
  localparam int          RECIP_255_SH = 27;

  // payload slots
  localparam logic [SLOT_W-1:0] SLOT_THROTTLE = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_YAW      = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_PITCH    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_LAST     = 3'd7;

  // input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // frame byte positions
  localparam logic [FRAME_IDX_W-1:0] IDX_HDR   = 5'd0;
  localparam logic [FRAME_IDX_W-1:0] IDX_FLAGS = 5'd23;
  localparam logic [FRAME_IDX_W-1:0] IDX_FTR   = 5'd24;

  typedef logic [CH_W-1:0] chan_t;
  // mapped channels kept per payload slot; the rest are fixed neutral
  typedef chan_t [PAYLOAD_LEN-1:0] snap_t;

  typedef struct packed {
    logic  valid;
    snap_t snap;
  } q_word_t;

endpackage

`default_nettype wire

[rtl/jsb_ifs.sv]
// Valid/ready channel interfaces for the bridge input and frame output.
`default_nettype none

interface jsb_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface jsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/joystick_to_sbus_bridge.sv]
// Joystick to SBUS bridge top level.
//
// in_ch carries words of two kinds: kind 0 is a joystick serial byte, kind 1
// is a frame transmit tick. A packet is sync 0xFF plus eight payload bytes;
// after the eighth byte the throttle, yaw, pitch and button channels update.
// Each tick yields one 25-byte SBUS frame on out_ch (header, 22 channel
// bytes, flag byte from cfg_wdata, footer with last_byte set).
// Throughput: one input word per cycle while in_ch.ready is high, one frame
// byte per cycle while out_ch.ready is high. Ticks that come faster than
// frames drain fill the snapshot queue of QDEPTH frames, and in_ch.ready
// then drops. With the serializer idle, a tick passes the stage-1 register,
// the queue write and the output register load before the first frame byte
// is valid.
// Reset (rst_n low, synchronous) puts the parser in sync hunt, sets all
// channels to 992, clears the flag register and empties the queue.
// When out_ch stalls, the frame byte holds and the parser keeps taking
// bytes until the queue has no room left for another tick.
`default_nettype none

module joystick_to_sbus_bridge
  import jsb_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  jsb_in_if.sink                  in_ch,
  jsb_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire logic [FLAGS_W-1:0] cfg_wdata
);

  q_word_t                       push;
  q_word_t                       head;
  logic                          pop;
  logic [$clog2(QDEPTH+1)-1:0]   q_count;

  jsb_front #(.QDEPTH(QDEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_count (q_count),
    .push    (push)
  );

  jsb_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  jsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[rtl/jsb_front.sv]
// Front end: packet parser, channel scaling pipeline and frame snapshot push.
`default_nettype none

module jsb_front
  import jsb_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  jsb_in_if.sink                          in_ch,
  input  wire logic [$clog2(QDEPTH+1)-1:0] q_count,
  output q_word_t                         push
);

  localparam int CW = $clog2(QDEPTH + 1);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                s1_valid_r, s1_tick_r, s1_commit_r;
  logic [SLOT_W-1:0]   s1_slot_r;
  logic [SCALED_W-1:0] s1_data_r;
  snap_t               pend_r;
  snap_t               cur_r;

  logic                accept;
  logic [CW:0]         used;
  logic                is_payload;
  logic [37:0]         prod_thr;
  logic [38:0]         prod_axis;
  chan_t               val;

  // a tick still in stage 1 holds a queue place already
  assign used        = {1'b0, q_count} + {{CW{1'b0}}, s1_valid_r & s1_tick_r};
  assign in_ch.ready = used < (CW+1)'(QDEPTH);
  assign accept      = in_ch.valid & in_ch.ready;
  assign is_payload  = accept & (in_ch.kind == KIND_BYTE) & (pos_r != '0);

  always_comb begin
    pos_nxt = pos_r;
    if (accept && in_ch.kind == KIND_BYTE) begin
      if (pos_r == '0) begin
        if (in_ch.rx_byte == SYNC_BYTE) pos_nxt = POS_W'(1);
      end else if (pos_r >= POS_W'(PAYLOAD_LEN)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      s1_valid_r <= is_payload | (accept & (in_ch.kind == KIND_TICK));
    end
  end

  always_ff @(posedge clk) begin
    s1_tick_r   <= in_ch.kind == KIND_TICK;
    s1_slot_r   <= SLOT_W'(pos_r - POS_W'(1));
    s1_commit_r <= pos_r >= POS_W'(PAYLOAD_LEN);
    s1_data_r   <= {11'd0, in_ch.rx_byte} * {8'd0, AXIS_GAIN};
  end

  // stage 1: constant division by reciprocal, per slot kind
  assign prod_thr  = {1'b0, s1_data_r[SCALED_W-1:1]} * {18'd0, RECIP_121} ;
  assign prod_axis = {1'b0, s1_data_r} * {19'd0, RECIP_255};

  always_comb begin
    case (s1_slot_r)
      SLOT_THROTTLE: val = CH_W'(prod_thr >> RECIP_121_SH) + CH_OFFSET;
      SLOT_YAW,
      SLOT_PITCH:    val = CH_W'(prod_axis >> RECIP_255_SH) + CH_OFFSET;
      default:       val = s1_data_r[CH_W-1:0] + CH_OFFSET;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && !s1_tick_r) pend_r[s1_slot_r] <= val;
  end

  // last slot comes straight from the scaler, the rest from the pending set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PAYLOAD_LEN; k++) cur_r[k] <= CH_NEUTRAL;
    end else if (s1_valid_r && !s1_tick_r && s1_commit_r) begin
      for (int k = 0; k < PAYLOAD_LEN - 1; k++) cur_r[k] <= pend_r[k];
      cur_r[SLOT_LAST] <= val;
    end
  end

  assign push.valid = s1_valid_r & s1_tick_r;
  assign push.snap  = cur_r;

endmodule

`default_nettype wire

[rtl/jsb_queue.sv]
// Small FIFO of channel snapshots between parser and frame serializer.
`default_nettype none

module jsb_queue
  import jsb_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  q_word_t                          push,
  input  wire logic                        pop,
  output q_word_t                          head,
  output logic [$clog2(QDEPTH+1)-1:0]      count
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  snap_t           mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) count_nxt = count_r + CW'(1);
    else if (!push.valid && pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid)
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.snap;
  end

  assign head.valid = count_r != '0;
  assign head.snap  = mem_r[rd_ptr_r];
  assign count      = count_r;

endmodule

`default_nettype wire

[rtl/jsb_back.sv]
// Back end: streams one 25-byte SBUS frame per queued snapshot.
`default_nettype none

module jsb_back
  import jsb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  q_word_t                 head,
  output logic                    pop,
  input  wire logic               cfg_we,
  input  wire logic [FLAGS_W-1:0] cfg_wdata,
  jsb_out_if.source               out_ch
);

  logic [FRAME_IDX_W-1:0]   cnt_r;
  logic [FLAGS_W-1:0]       flags_r;
  logic                     out_valid_r;
  logic [7:0]               byte_r;
  logic                     last_r;

  chan_t                    ch [CHANNEL_COUNT];
  logic [CH_BYTES*8-1:0]    ch_bits;
  logic [CH_BYTES-1:0][7:0] packed_bytes;
  logic [FRAME_IDX_W-1:0]   pidx;
  logic [7:0]               byte_nxt;
  logic                     load;

  // slot to channel map; unmapped channels stay neutral
  always_comb begin
    for (int i = 0; i < CHANNEL_COUNT; i++) ch[i] = CH_NEUTRAL;
    ch[2] = head.snap[0];
    ch[3] = head.snap[1];
    ch[1] = head.snap[2];
    for (int k = 3; k < PAYLOAD_LEN; k++) ch[k+3] = head.snap[k];
  end

  // channels packed LSB first, then cut into bytes
  always_comb begin
    ch_bits = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++)
      ch_bits[i*CH_W +: CH_W] = ch[i];
  end

  assign packed_bytes = ch_bits;

  assign pidx = cnt_r - FRAME_IDX_W'(1);

  always_comb begin
    case (cnt_r)
      IDX_HDR:   byte_nxt = HDR_BYTE;
      IDX_FLAGS: byte_nxt = {{(8-FLAGS_W){1'b0}}, flags_r};
      IDX_FTR:   byte_nxt = FTR_BYTE;
      default:   byte_nxt = packed_bytes[pidx];
    endcase
  end

  assign load = head.valid & (~out_valid_r | out_ch.ready);
  assign pop  = load & (cnt_r == IDX_FTR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) flags_r <= cfg_wdata;
      if (load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= (cnt_r == IDX_FTR) ? IDX_HDR : cnt_r + FRAME_IDX_W'(1);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= cnt_r == IDX_FTR;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = byte_r;
  assign out_ch.last_byte  = last_r;

endmodule

`default_nettype wire

[test/sbus_frame_checker.sv]
// Watches both channels of the bridge, predicts every SBUS frame byte and compares.
module sbus_frame_checker
  import jsb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  jsb_in_if                  in_ch,
  jsb_out_if                 out_ch,
  input  logic               cfg_we,
  input  logic [FLAGS_W-1:0] cfg_wdata,
  output int                 errors,
  output int                 pending,
  output int                 bytes_checked
);

  localparam int CH_PITCH     = 1;
  localparam int CH_THROTTLE  = 2;
  localparam int CH_YAW       = 3;
  localparam int CH_BUTTON0   = 6;
  localparam int BUTTON_COUNT = 5;
  localparam int THROTTLE_DIV = 242;
  localparam int AXIS_DIV     = 255;
  localparam int MAX_PRINTED  = 100;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  frame_byte_t        frame_due[$];
  frame_byte_t        want;
  logic [POS_W-1:0]   parse_pos;
  logic [7:0]         payload[PAYLOAD_LEN];
  chan_t              channel[CHANNEL_COUNT];
  logic [FLAGS_W-1:0] flags;

  function automatic chan_t scale_axis(input logic [7:0] b, input int div);
    int v;
    v = int'(b) * int'(AXIS_GAIN) / div + int'(CH_OFFSET);
    return v[CH_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    // keep the log short when everything goes wrong at once
    if (errors < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic take_word(input logic kind, input logic [7:0] b);
    logic [CHANNEL_COUNT*CH_W-1:0] packed_ch;
    int v;
    if (kind == KIND_TICK) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) packed_ch[i*CH_W +: CH_W] = channel[i];
      frame_due.push_back('{HDR_BYTE, 1'b0});
      for (int j = 0; j < CH_BYTES; j++) frame_due.push_back('{packed_ch[j*8 +: 8], 1'b0});
      frame_due.push_back('{8'(flags), 1'b0});
      frame_due.push_back('{FTR_BYTE, 1'b1});
    end else if (parse_pos == 0) begin
      // hunting: anything but sync is dropped
      if (b == SYNC_BYTE) parse_pos = 1;
    end else begin
      payload[SLOT_W'(parse_pos - POS_W'(1))] = b;
      if (parse_pos == PAYLOAD_LEN) begin
        channel[0]           = CH_NEUTRAL;
        channel[CH_THROTTLE] = scale_axis(payload[SLOT_THROTTLE], THROTTLE_DIV);
        channel[CH_YAW]      = scale_axis(payload[SLOT_YAW], AXIS_DIV);
        channel[CH_PITCH]    = scale_axis(payload[SLOT_PITCH], AXIS_DIV);
        for (int k = 0; k < BUTTON_COUNT; k++) begin
          // buttons wrap to 11 bits
          v = int'(payload[SLOT_PITCH + 1 + k]) * int'(AXIS_GAIN) + int'(CH_OFFSET);
          channel[CH_BUTTON0 + k] = v[CH_W-1:0];
        end
        parse_pos = 0;
      end else begin
        parse_pos++;
      end
    end
  endtask

  initial begin
    errors        = 0;
    pending       = 0;
    bytes_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_pos = 0;
      flags     = '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) channel[i] = CH_NEUTRAL;
      frame_due.delete();
    end else begin
      if (cfg_we) flags = cfg_wdata;
      if (in_ch.valid && in_ch.ready) take_word(in_ch.kind, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (frame_due.size() == 0) begin
          report_mismatch($sformatf("frame byte %h (last %b) with nothing due",
                                    out_ch.frame_byte, out_ch.last_byte));
        end else begin
          want = frame_due.pop_front();
          if (out_ch.frame_byte !== want.value || out_ch.last_byte !== want.last)
            report_mismatch($sformatf("byte %0d of frame: got %h last %b, want %h last %b",
                                      bytes_checked % FRAME_LEN, out_ch.frame_byte,
                                      out_ch.last_byte, want.value, want.last));
        end
        bytes_checked++;
      end
    end
    pending = frame_due.size();
  end

endmodule

[test/testbench.sv]
// Top of the bridge testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
  import jsb_pkg::*;

  localparam int PHASE_ITEMS = 30;
  localparam int DRAIN_GAP   = 8;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [FLAGS_W-1:0] cfg_wdata;
  int                 idle_pct;
  int                 stall_pct;
  int                 words_sent;
  int                 ticks_sent;
  int                 packets_sent;
  int                 ignored_sent;
  int                 errors;
  int                 pending;
  int                 bytes_checked;

  jsb_in_if  in_ch();
  jsb_out_if out_ch();

  joystick_to_sbus_bridge dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sbus_frame_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic kind, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid   = 1'b0;
      in_ch.rx_byte = 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.kind    = kind;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    words_sent++;
    if (kind == KIND_TICK) ticks_sent++;
  endtask

  // sync plus len payload words, with ticks dropped in mid-packet now and then
  task automatic send_packet(input int len);
    send_word(KIND_BYTE, SYNC_BYTE);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) send_word(KIND_TICK, 8'($urandom_range(0, 255)));
      send_word(KIND_BYTE, ($urandom_range(0, 9) == 0) ? SYNC_BYTE
                                                       : 8'($urandom_range(0, 255)));
    end
    if (len == PAYLOAD_LEN) packets_sent++;
  endtask

  task automatic send_fixed_packet(input logic [7:0] b);
    send_word(KIND_BYTE, SYNC_BYTE);
    repeat (PAYLOAD_LEN) send_word(KIND_BYTE, b);
    send_word(KIND_TICK, 8'hFF);
    packets_sent++;
  endtask

  // flags only change with nothing in flight
  task automatic drain_and_set_flags(input logic [FLAGS_W-1:0] v);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(input int in_idle, input int out_stall,
                           input logic [FLAGS_W-1:0] flag_val);
    int base;
    int pick;
    drain_and_set_flags(flag_val);
    idle_pct  = in_idle;
    stall_pct = out_stall;
    base      = words_sent - ignored_sent;
    while (words_sent - ignored_sent - base < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_packet(PAYLOAD_LEN);
      end else if (pick < 70) begin
        // cut short: the next sync lands in the payload
        send_packet($urandom_range(0, PAYLOAD_LEN - 1));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 5)) send_word(KIND_TICK, 8'($urandom_range(0, 255)));
      end else begin
        send_word(KIND_BYTE, 8'($urandom_range(0, 254)));
        ignored_sent++;
      end
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_BYTE;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    words_sent    = 0;
    ticks_sent    = 0;
    packets_sent  = 0;
    ignored_sent  = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset frame: all channels neutral, flags clear
    send_word(KIND_TICK, 8'h00);
    drain_and_set_flags(4'hF);
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_BYTE, 8'hFE);
    ignored_sent += 2;
    send_fixed_packet(8'h00);
    // all-0xFF payload: sync inside payload and button wrap
    send_fixed_packet(8'hFF);

    run_phase(0, 0, 4'($urandom_range(1, 14)));
    run_phase(55, 0, 4'h0);
    run_phase(0, 55, 4'hF);
    run_phase(24, 24, 4'($urandom_range(0, 15)));
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("testbench: %0d words in (%0d ticks, %0d full packets, %0d ignored bytes)",
             words_sent, ticks_sent, packets_sent, ignored_sent);
    $display("testbench: %0d frame bytes checked over four stall mixes and flag values 0..15",
             bytes_checked);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/jsb_pkg.sv
rtl/jsb_ifs.sv
rtl/jsb_front.sv
rtl/jsb_queue.sv
rtl/jsb_back.sv
rtl/joystick_to_sbus_bridge.sv
test/sbus_frame_checker.sv
test/testbench.sv
